/* src/tri_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tri_pkg
// Shared constants, payload words and internal status structs of the
// triangle edge rasterizer.
// ----------------------------------------------------------------------------
package tri_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int FRACTION_BITS = 4;

    localparam int PIXEL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int X_W         = $clog2(SCREEN_WIDTH + 1);
    localparam int Y_W         = $clog2(SCREEN_HEIGHT + 1);

    // fixed field widths of the item and result words
    localparam int KIND_W  = 2;
    localparam int VERT_W  = 16;
    localparam int COLOR_W = 8;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int COUNT_W = 17;

    // arithmetic widths
    localparam int BOX_W  = VERT_W + 1;
    localparam int PX_W   = ((X_W > Y_W) ? X_W : Y_W) + FRACTION_BITS;
    localparam int DIFF_W = ((PX_W > VERT_W) ? PX_W : VERT_W) + 2;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int EDGE_W = PROD_W + 1;
    localparam int STEP_W = BOX_W + FRACTION_BITS;

    localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_DRAW  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(2);

    typedef logic signed [EDGE_W-1:0] edge_t;
    typedef logic signed [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [VERT_W-1:0] vertex_a_x;
        logic signed [VERT_W-1:0] vertex_a_y;
        logic signed [VERT_W-1:0] vertex_b_x;
        logic signed [VERT_W-1:0] vertex_b_y;
        logic signed [VERT_W-1:0] vertex_c_x;
        logic signed [VERT_W-1:0] vertex_c_y;
        logic [COLOR_W-1:0]       fill_color;
        logic [COL_W-1:0]         read_column;
        logic [ROW_W-1:0]         read_row;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_value;
        logic [COUNT_W-1:0] pixels_written;
    } result_t;

    // triangle setup handed from setup to scan
    typedef struct packed {
        logic [X_W-1:0]     x_first;
        logic [X_W-1:0]     x_last;
        logic [Y_W-1:0]     y_first;
        logic [Y_W-1:0]     y_last;
        logic               empty;
        logic [ADDR_W-1:0]  start_addr;
        logic [COLOR_W-1:0] color;
        edge_t [2:0]        e_start;
        step_t [2:0]        dx;
        step_t [2:0]        dy;
    } geo_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } pixel_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } pixel_rd_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
    } scan_status_t;

endpackage
`default_nettype wire

/* src/triangle_edge_rasterizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Edge-function triangle fill over an RGB332 frame store, with clear and
// single-pixel read.
// ----------------------------------------------------------------------------
//  channel   handshake                    word
//  -------   --------------------------   ------------------------------
//  item      item_valid / item_ready      item   (tri_pkg::item_t)
//  result    result_valid / result_ready  result (tri_pkg::result_t)
//
//  One item at a time, from acceptance through to its result.
//  Clear: one store write a cycle, over every address of the store.
//  Triangle: box, start address, six products through one multiplier,
//  hand-off, then the clipped box at one pixel a cycle, set by the single
//  store write port, then the result. Read: paced by the registered read
//  port of the store. The store holds no reset state; a clear
//  item must precede the first read. A finished result waits in the output
//  register; a new item is taken while it waits, and its own result stalls
//  until the register frees.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire tri_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output tri_pkg::result_t       result
);
    import tri_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_CLEAR     = 6'b000010,
        S_SETUP     = 6'b000100,
        S_SCAN      = 6'b001000,
        S_READ_WAIT = 6'b010000,
        S_RESULT    = 6'b100000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

    state_t             state_reg;
    logic               result_valid_reg;
    result_t            result_reg;
    logic [ADDR_W-1:0]  clear_addr_reg;
    logic               in_range_reg;
    logic [COLOR_W-1:0] res_value_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic               accept;
    logic               in_range;
    logic               setup_start;
    logic               setup_done;
    logic               scan_start;
    logic               out_free;
    geo_t               geo;
    pixel_wr_t          scan_wr;
    pixel_wr_t          store_wr;
    pixel_rd_t          store_rd;
    scan_status_t       scan_status;
    logic [COLOR_W-1:0] rd_data;

    assign item_ready  = (state_reg == S_IDLE);
    assign accept      = item_valid && item_ready;
    assign in_range    = (int'(item.read_column) < SCREEN_WIDTH)
                      && (int'(item.read_row) < SCREEN_HEIGHT);
    assign setup_start = accept && (item.kind == KIND_DRAW);
    assign scan_start  = (state_reg == S_SETUP) && setup_done;
    assign out_free    = !result_valid_reg || result_ready;

    assign store_rd.en   = accept && (item.kind == KIND_READ) && in_range;
    assign store_rd.addr = ADDR_W'(int'(item.read_row) * SCREEN_WIDTH
                                   + int'(item.read_column));

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            store_wr.en   = 1'b1;
            store_wr.addr = clear_addr_reg;
            store_wr.data = '0;
        end
        else
        begin
            store_wr = scan_wr;
        end
    end

    tri_setup u_setup (
        .clk   (clk),
        .rst_n (rst_n),
        .start (setup_start),
        .item  (item),
        .done  (setup_done),
        .geo   (geo)
    );

    tri_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .geo    (geo),
        .wr     (scan_wr),
        .status (scan_status)
    );

    tri_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RESULT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (item.kind == KIND_CLEAR)
                        begin
                            state_reg <= S_CLEAR;
                        end
                        else if (item.kind == KIND_DRAW)
                        begin
                            state_reg <= S_SETUP;
                        end
                        else if (item.kind == KIND_READ)
                        begin
                            state_reg <= S_READ_WAIT;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_CLEAR:
                begin
                    if (clear_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_SETUP:
                begin
                    if (setup_done)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_status.done)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_READ_WAIT:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    // hold until the output register frees
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clear_addr_reg <= '0;
            in_range_reg   <= in_range;
            res_value_reg  <= '0;
            res_count_reg  <= '0;
        end
        if (state_reg == S_CLEAR)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            res_count_reg  <= COUNT_W'(PIXEL_COUNT);
        end
        if (state_reg == S_SCAN && scan_status.done)
        begin
            res_count_reg <= scan_status.count;
        end
        if (state_reg == S_READ_WAIT && in_range_reg)
        begin
            res_value_reg <= rd_data;
        end
        if (state_reg == S_RESULT && out_free)
        begin
            result_reg.pixel_value    <= res_value_reg;
            result_reg.pixels_written <= res_count_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_wr.en && store_rd.en))
        else $error("store written and read in the same cycle");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !store_wr.en)
        else $error("store written while idle");

    a_setup_owner: assert property (@(posedge clk) disable iff (!rst_n)
        setup_done |-> (state_reg == S_SETUP))
        else $error("setup finished outside the setup state");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_free) |=> result_valid_reg)
        else $error("finished result not presented");

endmodule
`default_nettype wire

/* src/tri_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tri_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tri_store (
    input  wire logic                     clk,
    input  wire tri_pkg::pixel_wr_t       wr,
    input  wire tri_pkg::pixel_rd_t       rd,
    output logic [tri_pkg::COLOR_W-1:0]   rd_data
);
    import tri_pkg::*;

    logic [COLOR_W-1:0] mem [PIXEL_COUNT];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* src/tri_setup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tri_setup
// Triangle setup: clipped bounding box, per-edge steps, start address, and
// the value of each edge at the first box pixel through one shared multiplier.
// ----------------------------------------------------------------------------
module tri_setup (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire tri_pkg::item_t  item,
    output logic                 done,
    output tri_pkg::geo_t        geo
);
    import tri_pkg::*;

    localparam logic [2:0] PH_BOX   = 3'd0;
    localparam logic [2:0] PH_FINAL = 3'd7;
    localparam int         ROUND    = (1 << FRACTION_BITS) - 1;

    logic                      busy_reg;
    logic [2:0]                phase_reg;
    logic                      done_reg;
    logic                      prod_valid_reg;
    logic [2:0]                prod_phase_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VERT_W-1:0]  vx_reg [3];
    logic signed [VERT_W-1:0]  vy_reg [3];
    logic [COLOR_W-1:0]        color_reg;
    geo_t                      geo_reg;

    logic signed [BOX_W-1:0]   x_lo_c, x_hi_c, y_lo_c, y_hi_c;
    step_t                     dx_c [3];
    step_t                     dy_c [3];
    logic signed [DIFF_W-1:0]  px_d, py_d;
    logic signed [DIFF_W-1:0]  dxv [3];
    logic signed [DIFF_W-1:0]  dyv [3];
    logic signed [DIFF_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0]  prod_c;

    function automatic logic signed [VERT_W-1:0] min3(
        logic signed [VERT_W-1:0] a, logic signed [VERT_W-1:0] b,
        logic signed [VERT_W-1:0] c);
        logic signed [VERT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [VERT_W-1:0] max3(
        logic signed [VERT_W-1:0] a, logic signed [VERT_W-1:0] b,
        logic signed [VERT_W-1:0] c);
        logic signed [VERT_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // whole pixels, truncated toward zero
    function automatic logic signed [BOX_W-1:0] to_pixel(logic signed [VERT_W-1:0] v);
        logic signed [BOX_W-1:0] w;
        w = BOX_W'(v);
        if (v < 0)
        begin
            w = w + BOX_W'(ROUND);
        end
        return w >>> FRACTION_BITS;
    endfunction

    function automatic logic signed [BOX_W-1:0] clip(logic signed [BOX_W-1:0] v, int lim);
        logic signed [BOX_W-1:0] l;
        l = BOX_W'(lim);
        if (v < 0)
        begin
            return '0;
        end
        return (v > l) ? l : v;
    endfunction

    always_comb
    begin
        x_lo_c = clip(to_pixel(min3(vx_reg[0], vx_reg[1], vx_reg[2])), SCREEN_WIDTH);
        x_hi_c = clip(to_pixel(max3(vx_reg[0], vx_reg[1], vx_reg[2])), SCREEN_WIDTH);
        y_lo_c = clip(to_pixel(min3(vy_reg[0], vy_reg[1], vy_reg[2])), SCREEN_HEIGHT);
        y_hi_c = clip(to_pixel(max3(vy_reg[0], vy_reg[1], vy_reg[2])), SCREEN_HEIGHT);
    end

    // edge k runs from vertex k to vertex (k+1) mod 3
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dx_c[k] = STEP_W'(BOX_W'(vy_reg[k]) - BOX_W'(vy_reg[(k + 1) % 3]))
                      <<< FRACTION_BITS;
            dy_c[k] = STEP_W'(BOX_W'(vx_reg[(k + 1) % 3]) - BOX_W'(vx_reg[k]))
                      <<< FRACTION_BITS;
        end
    end

    always_comb
    begin
        px_d = $signed(DIFF_W'(geo_reg.x_first)) <<< FRACTION_BITS;
        py_d = $signed(DIFF_W'(geo_reg.y_first)) <<< FRACTION_BITS;
        for (int k = 0; k < 3; k++)
        begin
            dxv[k] = DIFF_W'(vx_reg[k]) - px_d;
            dyv[k] = DIFF_W'(vy_reg[k]) - py_d;
        end
    end

    // odd phases give the product that is added, even phases the one subtracted
    always_comb
    begin
        unique case (phase_reg)
            3'd1:    begin op_a = dxv[0]; op_b = dyv[1]; end
            3'd2:    begin op_a = dyv[0]; op_b = dxv[1]; end
            3'd3:    begin op_a = dxv[1]; op_b = dyv[2]; end
            3'd4:    begin op_a = dyv[1]; op_b = dxv[2]; end
            3'd5:    begin op_a = dxv[2]; op_b = dyv[0]; end
            3'd6:    begin op_a = dyv[2]; op_b = dxv[0]; end
            default: begin op_a = '0;     op_b = '0;     end
        endcase
        prod_c = op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            phase_reg      <= PH_BOX;
            done_reg       <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= busy_reg && (phase_reg != PH_BOX) && (phase_reg != PH_FINAL);
            done_reg       <= busy_reg && !start && (phase_reg == PH_FINAL);
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_BOX;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 3'd1;
                if (phase_reg == PH_FINAL)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_c;
        prod_phase_reg <= phase_reg;
        if (start)
        begin
            vx_reg[0] <= item.vertex_a_x;
            vy_reg[0] <= item.vertex_a_y;
            vx_reg[1] <= item.vertex_b_x;
            vy_reg[1] <= item.vertex_b_y;
            vx_reg[2] <= item.vertex_c_x;
            vy_reg[2] <= item.vertex_c_y;
            color_reg <= item.fill_color;
        end
        if (busy_reg && phase_reg == PH_BOX)
        begin
            geo_reg.x_first <= X_W'(x_lo_c);
            geo_reg.x_last  <= X_W'(x_hi_c - BOX_W'(1));
            geo_reg.y_first <= Y_W'(y_lo_c);
            geo_reg.y_last  <= Y_W'(y_hi_c - BOX_W'(1));
            geo_reg.empty   <= (x_lo_c >= x_hi_c) || (y_lo_c >= y_hi_c);
            geo_reg.color   <= color_reg;
            for (int k = 0; k < 3; k++)
            begin
                geo_reg.dx[k] <= dx_c[k];
                geo_reg.dy[k] <= dy_c[k];
            end
        end
        if (busy_reg && phase_reg == 3'd1)
        begin
            geo_reg.start_addr <= ADDR_W'(int'(geo_reg.y_first) * SCREEN_WIDTH
                                          + int'(geo_reg.x_first));
        end
        if (prod_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (prod_phase_reg == 3'(2 * k + 1))
                begin
                    geo_reg.e_start[k] <= EDGE_W'(prod_reg);
                end
                else if (prod_phase_reg == 3'(2 * k + 2))
                begin
                    geo_reg.e_start[k] <= $signed(geo_reg.e_start[k]) - EDGE_W'(prod_reg);
                end
            end
        end
    end

    assign done = done_reg;
    assign geo  = geo_reg;

endmodule
`default_nettype wire

/* src/tri_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tri_scan
// Box walker: one pixel per cycle, edge values stepped incrementally, covered
// pixels written to the frame store and counted.
// ----------------------------------------------------------------------------
module tri_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tri_pkg::geo_t       geo,
    output tri_pkg::pixel_wr_t       wr,
    output tri_pkg::scan_status_t    status
);
    import tri_pkg::*;

    logic               active_reg;
    logic               done_reg;
    logic [X_W-1:0]     x_reg;
    logic [Y_W-1:0]     y_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  row_addr_reg;
    logic [COUNT_W-1:0] count_reg;
    edge_t              e_reg [3];
    edge_t              row_e_reg [3];

    logic               covered;
    logic [2:0]         nonneg, nonpos;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nonneg[k] = !e_reg[k][EDGE_W-1];
            nonpos[k] = e_reg[k][EDGE_W-1] || (e_reg[k] == '0);
        end
        covered = (&nonneg) || (&nonpos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= start ? geo.empty
                              : (active_reg && x_reg == geo.x_last && y_reg == geo.y_last);
            if (start)
            begin
                active_reg <= !geo.empty;
            end
            else if (active_reg && x_reg == geo.x_last && y_reg == geo.y_last)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg        <= geo.x_first;
            y_reg        <= geo.y_first;
            addr_reg     <= geo.start_addr;
            row_addr_reg <= geo.start_addr;
            count_reg    <= '0;
            for (int k = 0; k < 3; k++)
            begin
                e_reg[k]     <= geo.e_start[k];
                row_e_reg[k] <= geo.e_start[k];
            end
        end
        else if (active_reg)
        begin
            count_reg <= count_reg + COUNT_W'(covered);
            if (x_reg == geo.x_last)
            begin
                // wrap to the start of the next row
                x_reg        <= geo.x_first;
                y_reg        <= y_reg + Y_W'(1);
                addr_reg     <= row_addr_reg + ADDR_W'(SCREEN_WIDTH);
                row_addr_reg <= row_addr_reg + ADDR_W'(SCREEN_WIDTH);
                for (int k = 0; k < 3; k++)
                begin
                    e_reg[k]     <= row_e_reg[k] + EDGE_W'($signed(geo.dy[k]));
                    row_e_reg[k] <= row_e_reg[k] + EDGE_W'($signed(geo.dy[k]));
                end
            end
            else
            begin
                x_reg    <= x_reg + X_W'(1);
                addr_reg <= addr_reg + ADDR_W'(1);
                for (int k = 0; k < 3; k++)
                begin
                    e_reg[k] <= e_reg[k] + EDGE_W'($signed(geo.dx[k]));
                end
            end
        end
    end

    assign wr.en         = active_reg && covered;
    assign wr.addr       = addr_reg;
    assign wr.data       = geo.color;
    assign status.done   = done_reg;
    assign status.count  = count_reg;

    a_inside_box: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (x_reg <= geo.x_last && y_reg <= geo.y_last))
        else $error("scan position outside the box");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg)
        else $error("scan restarted while walking a box");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !active_reg && !wr.en)
        else $error("scan reports done while still writing");

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle edge rasterizer. A pixel-exact model of
// the frame store predicts every result word; directed corners come first,
// then a long random mix of draws, reads, clears and spare kinds under random
// handshake gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import tri_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = KIND_W'(3);
    localparam int ONE          = 1 << FRACTION_BITS;
    localparam int RANDOM_ITEMS = 880;
    localparam int LONG_HOLD    = 2500;
    localparam int DRAIN_CYCLES = 100;
    localparam longint RUN_LIMIT_NS = 100_000_000;

    class raster_scoreboard;
        logic [COLOR_W-1:0] frame_pixels [PIXEL_COUNT];
        result_t awaited[$];
        int mismatches;
        int checked;

        function new();
            foreach (frame_pixels[k])
            begin
                frame_pixels[k] = '0;
            end
            mismatches = 0;
            checked = 0;
        endfunction

        task report(string msg);
            if (mismatches < 100)
            begin
                $display("mismatch at %0t: %s", $time, msg);
            end
            mismatches++;
        endtask

        function longint edge_of(longint px, longint py, longint ax, longint ay,
                                 longint bx, longint by);
            return (ax - px) * (by - py) - (ay - py) * (bx - px);
        endfunction

        function int lowest(int a, int b, int c);
            int m;
            m = (a < b) ? a : b;
            return (m < c) ? m : c;
        endfunction

        function int highest(int a, int b, int c);
            int m;
            m = (a > b) ? a : b;
            return (m > c) ? m : c;
        endfunction

        task note_item(item_t it);
            result_t want;
            int ax, ay, bx, by, cx, cy;
            int x_lo, x_hi, y_lo, y_hi;
            longint px, py, e0, e1, e2;
            int unsigned count;
            want = '0;
            count = 0;
            case (it.kind)
            KIND_CLEAR:
            begin
                foreach (frame_pixels[k])
                begin
                    frame_pixels[k] = '0;
                end
                count = PIXEL_COUNT;
            end
            KIND_DRAW:
            begin
                ax = it.vertex_a_x;
                ay = it.vertex_a_y;
                bx = it.vertex_b_x;
                by = it.vertex_b_y;
                cx = it.vertex_c_x;
                cy = it.vertex_c_y;
                // truncate toward zero, box exclusive at the top end
                x_lo = lowest(ax, bx, cx) / ONE;
                x_hi = highest(ax, bx, cx) / ONE;
                y_lo = lowest(ay, by, cy) / ONE;
                y_hi = highest(ay, by, cy) / ONE;
                if (x_lo < 0) x_lo = 0;
                if (y_lo < 0) y_lo = 0;
                if (x_hi > SCREEN_WIDTH) x_hi = SCREEN_WIDTH;
                if (y_hi > SCREEN_HEIGHT) y_hi = SCREEN_HEIGHT;
                for (int y = y_lo; y < y_hi; y++)
                begin
                    py = longint'(y) * ONE;
                    for (int x = x_lo; x < x_hi; x++)
                    begin
                        px = longint'(x) * ONE;
                        e0 = edge_of(px, py, ax, ay, bx, by);
                        e1 = edge_of(px, py, bx, by, cx, cy);
                        e2 = edge_of(px, py, cx, cy, ax, ay);
                        if ((e0 >= 0 && e1 >= 0 && e2 >= 0) ||
                            (e0 <= 0 && e1 <= 0 && e2 <= 0))
                        begin
                            frame_pixels[y * SCREEN_WIDTH + x] = it.fill_color;
                            count++;
                        end
                    end
                end
            end
            KIND_READ:
            begin
                if (it.read_column < SCREEN_WIDTH && it.read_row < SCREEN_HEIGHT)
                begin
                    want.pixel_value =
                        frame_pixels[int'(it.read_row) * SCREEN_WIDTH + int'(it.read_column)];
                end
            end
            default:
            begin
            end
            endcase
            want.pixels_written = COUNT_W'(count);
            awaited.push_back(want);
        endtask

        task check_result(result_t got);
            result_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing outstanding", checked));
            end
            else
            begin
                want = awaited.pop_front();
                if (got.pixel_value !== want.pixel_value)
                begin
                    report($sformatf("result %0d pixel_value %0h, want %0h",
                                     checked, got.pixel_value, want.pixel_value));
                end
                if (got.pixels_written !== want.pixels_written)
                begin
                    report($sformatf("result %0d pixels_written %0d, want %0d",
                                     checked, got.pixels_written, want.pixels_written));
                end
            end
        endtask
    endclass

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    item_ready;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    raster_scoreboard sb;
    bit hold_request = 1'b0;
    int last_x = SCREEN_WIDTH / 2;
    int last_y = SCREEN_HEIGHT / 2;

    triangle_edge_rasterizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL triangle_edge_rasterizer");
        $finish;
    end

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic item_t noise_word();
        item_t w;
        w.kind        = KIND_W'($urandom);
        w.vertex_a_x  = VERT_W'($urandom);
        w.vertex_a_y  = VERT_W'($urandom);
        w.vertex_b_x  = VERT_W'($urandom);
        w.vertex_b_y  = VERT_W'($urandom);
        w.vertex_c_x  = VERT_W'($urandom);
        w.vertex_c_y  = VERT_W'($urandom);
        w.fill_color  = COLOR_W'($urandom);
        w.read_column = COL_W'($urandom);
        w.read_row    = ROW_W'($urandom);
        return w;
    endfunction

    function automatic item_t kind_word(logic [KIND_W-1:0] kind);
        item_t w;
        w = noise_word();
        w.kind = kind;
        return w;
    endfunction

    function automatic item_t tri_word(int ax, int ay, int bx, int by, int cx, int cy,
                                       int color);
        item_t w;
        w = kind_word(KIND_DRAW);
        w.vertex_a_x = VERT_W'(ax);
        w.vertex_a_y = VERT_W'(ay);
        w.vertex_b_x = VERT_W'(bx);
        w.vertex_b_y = VERT_W'(by);
        w.vertex_c_x = VERT_W'(cx);
        w.vertex_c_y = VERT_W'(cy);
        w.fill_color = COLOR_W'(color);
        return w;
    endfunction

    function automatic item_t read_word(int col, int row);
        item_t w;
        w = kind_word(KIND_READ);
        w.read_column = COL_W'(col);
        w.read_row    = ROW_W'(row);
        return w;
    endfunction

    // pixel center plus a random Q offset within +-spread pixels
    function automatic int jitter(int centre, int spread);
        return centre * ONE + int'($urandom_range(0, 2 * spread * ONE)) - spread * ONE;
    endfunction

    function automatic item_t make_triangle(int spread);
        last_x = int'($urandom_range(0, SCREEN_WIDTH + 19)) - 10;
        last_y = int'($urandom_range(0, SCREEN_HEIGHT + 19)) - 10;
        return tri_word(jitter(last_x, spread), jitter(last_y, spread),
                        jitter(last_x, spread), jitter(last_y, spread),
                        jitter(last_x, spread), jitter(last_y, spread),
                        $urandom_range(0, 255));
    endfunction

    // hold valid high until the word is taken; keep it high when no gap follows
    task automatic offer(input item_t word, input int gap);
        item       <= word;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        sb.note_item(word);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                sb.check_result(result);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
                free_left    = 0;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (free_left > 0)
                    free_left--;
                else if ($urandom_range(0, 99) < 3)
                    free_left = $urandom_range(100, 400);
                else
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : item_source
        item_t w;
        int r, sel, gap, side, lo, hi, col, row;
        int burst_left, quiet_left, clears_left, wide_left;
        sb = new();
        burst_left  = 0;
        quiet_left  = 0;
        clears_left = 3;
        wide_left   = 2;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clear first: nothing may be read before the store is written
        offer(kind_word(KIND_CLEAR), pick_gap());
        offer(read_word(0, 0), pick_gap());
        offer(tri_word(0, 0, 8 * ONE, 0, 0, 8 * ONE, 8'hAB), pick_gap());
        offer(read_word(0, 0), pick_gap());
        offer(read_word(7, 0), pick_gap());
        // collinear vertices
        offer(tri_word(2 * ONE, 2 * ONE, 10 * ONE, 10 * ONE, 6 * ONE, 6 * ONE, 8'h5C),
              pick_gap());
        offer(read_word(6, 6), pick_gap());
        // all vertices inside one pixel: empty box
        offer(tri_word(84, 88, 92, 81, 88, 94, 8'h11), pick_gap());
        // slightly negative corner truncates to zero
        offer(tri_word(-8, -8, 40 * ONE, -8, -8, 40 * ONE, 8'h00), pick_gap());
        offer(tri_word(-32768, -32768, 32767, -32768, -32768, 32767, 8'hFF), pick_gap());
        offer(read_word(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1), pick_gap());
        offer(read_word(0, 0), pick_gap());
        offer(tri_word(300 * ONE + 7, 220 * ONE, 300 * ONE, 250 * ONE + 3,
                       330 * ONE, 250 * ONE, 8'h96), pick_gap());
        offer(read_word(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1), pick_gap());
        offer(read_word(SCREEN_WIDTH, 0), pick_gap());
        offer(read_word(0, SCREEN_HEIGHT), pick_gap());
        offer(read_word(511, 255), pick_gap());
        w = '1;
        w.kind = KIND_SPARE;
        offer(w, pick_gap());
        offer(tri_word(32767, 32767, -32768, 32767, 32767, -32768, 8'h3C), pick_gap());
        offer(read_word(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2), pick_gap());
        offer(kind_word(KIND_CLEAR), pick_gap());
        offer(read_word(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1), pick_gap());
        offer(read_word(100, 50), pick_gap());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // stall the result side while fast reads keep coming
            if (i == 250 || i == 600)
            begin
                hold_request = 1'b1;
                burst_left   = 30;
            end
            if (quiet_left == 0 && $urandom_range(0, 49) == 0)
                quiet_left = $urandom_range(20, 60);

            r = $urandom_range(0, 999);
            if (burst_left > 0)
                sel = 2;
            else if (r < 4 && clears_left > 0)
                sel = 0;
            else if (r < 30)
                sel = 1;
            else if (r < 380)
                sel = 2;
            else if (r < 460)
                sel = 3;
            else if (r < 463 && wide_left > 0)
                sel = 4;
            else if (r < 520)
                sel = 5;
            else
                sel = 6;

            case (sel)
            0:
            begin
                w = kind_word(KIND_CLEAR);
                clears_left--;
            end
            1:
            begin
                w = kind_word(KIND_SPARE);
            end
            2:
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                begin
                    col = last_x + int'($urandom_range(0, 48)) - 24;
                    row = last_y + int'($urandom_range(0, 48)) - 24;
                    col = (col < 0) ? 0 : (col >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : col;
                    row = (row < 0) ? 0 : (row >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : row;
                end
                else if (r < 8)
                begin
                    col = $urandom_range(0, SCREEN_WIDTH - 1);
                    row = $urandom_range(0, SCREEN_HEIGHT - 1);
                end
                else
                begin
                    col = $urandom_range(0, 511);
                    row = $urandom_range(0, 255);
                end
                w = read_word(col, row);
            end
            3:
            begin
                // whole triangle off one side of the screen
                side = $urandom_range(0, 3);
                lo = side[0] ? -32768 : ((side < 2) ? SCREEN_WIDTH : SCREEN_HEIGHT) * ONE;
                hi = side[0] ? -ONE : 32767;
                w = kind_word(KIND_DRAW);
                if (side < 2)
                begin
                    w.vertex_a_x = VERT_W'(lo + int'($urandom_range(0, hi - lo)));
                    w.vertex_b_x = VERT_W'(lo + int'($urandom_range(0, hi - lo)));
                    w.vertex_c_x = VERT_W'(lo + int'($urandom_range(0, hi - lo)));
                end
                else
                begin
                    w.vertex_a_y = VERT_W'(lo + int'($urandom_range(0, hi - lo)));
                    w.vertex_b_y = VERT_W'(lo + int'($urandom_range(0, hi - lo)));
                    w.vertex_c_y = VERT_W'(lo + int'($urandom_range(0, hi - lo)));
                end
            end
            4:
            begin
                w = kind_word(KIND_DRAW);
                wide_left--;
            end
            5:
            begin
                w = make_triangle($urandom_range(8, 48));
            end
            default:
            begin
                w = make_triangle($urandom_range(1, 20));
            end
            endcase

            gap = (burst_left > 0 || quiet_left > 0) ? 0 : pick_gap();
            if (burst_left > 0) burst_left--;
            if (quiet_left > 0) quiet_left--;
            offer(w, gap);
        end

        item_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS triangle_edge_rasterizer");
        else
            $display("FAIL triangle_edge_rasterizer");
        $finish;
    end
endmodule
